// File: design/mcf_pkg.sv
// ----------------------------------------------------------------------------
// mcf_pkg
// Shared constants, types and register codes of the multipath channel core.
// ----------------------------------------------------------------------------
`default_nettype none

package mcf_pkg;

	// path count, delay limit and saturation width of the channel model
	localparam int MAX_PATHS   = 4;
	localparam int MAX_DELAY   = 1023;
	localparam int SAMPLE_BITS = 16;

	// field and storage sizes
	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int DELAY_W    = 10;
	localparam int LINE_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int FILL_W     = ADDR_W + 1;
	localparam int ENTRY_W    = 2 * SAMPLE_W;
	localparam int TAP_REGS   = 4;
	localparam int TAP_IDX_W  = $clog2(TAP_REGS);
	localparam int TAP_W      = $clog2(MAX_PATHS + 1);
	localparam int PROD_W     = SAMPLE_W + GAIN_W;
	localparam int ACC_W      = PROD_W + 4;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 42;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATH_TAP_FIRST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATH_TAP_LAST  = 3'd4;

	// reset value of the direct gain
	localparam logic [GAIN_W-1:0] DIRECT_GAIN_RESET = 16'h7fff;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// one tap read on its way to the multipliers
	typedef struct packed {
		logic                     vld;
		logic                     first;
		logic                     last;
		logic                     live;
		logic signed [GAIN_W-1:0] gain_re;
		logic signed [GAIN_W-1:0] gain_im;
	} tag_t;

endpackage

`default_nettype wire

// File: design/mcf_mac.sv
// ----------------------------------------------------------------------------
// mcf_mac
// Complex multiply-accumulate over the taps of one sample, then rounding
// to Q1.15 and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mcf_mac (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire mcf_pkg::tag_t                     tag_s1,
	input  wire logic [mcf_pkg::ENTRY_W-1:0]       rdata,
	output logic                                   done,
	output logic signed [mcf_pkg::SAMPLE_W-1:0]    res_re,
	output logic signed [mcf_pkg::SAMPLE_W-1:0]    res_im
);

	localparam int PW = mcf_pkg::PROD_W;
	localparam int AW = mcf_pkg::ACC_W;
	localparam int SW = mcf_pkg::SAMPLE_W;
	localparam int QW = AW - 15;
	localparam logic signed [AW-1:0] ROUND_HALF = AW'(16384);
	localparam logic signed [QW-1:0] SAT_HI = QW'((1 <<< (mcf_pkg::SAMPLE_BITS - 1)) - 1);
	localparam logic signed [QW-1:0] SAT_LO = QW'(-(1 <<< (mcf_pkg::SAMPLE_BITS - 1)));

	logic signed [SW-1:0] d_re;
	logic signed [SW-1:0] d_im;
	logic signed [PW-1:0] rr_s2, ii_s2, ri_s2, ir_s2;
	logic                 vld_s2, first_s2, last_s2;
	logic signed [PW:0]   p_re, p_im;
	logic signed [AW-1:0] acc_base_re, acc_base_im;
	logic signed [AW-1:0] acc_re_q, acc_im_q;
	logic                 done_q;
	logic signed [AW-1:0] rnd_re, rnd_im;
	logic signed [QW-1:0] q_re, q_im;
	logic signed [QW-1:0] sat_re, sat_im;

	// entries never written since reset read as zero
	assign d_re = tag_s1.live ? rdata[SW-1:0] : '0;
	assign d_im = tag_s1.live ? rdata[2*SW-1:SW] : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s2 <= tag_s1.gain_re * d_re;
			ii_s2 <= tag_s1.gain_im * d_im;
			ri_s2 <= tag_s1.gain_re * d_im;
			ir_s2 <= tag_s1.gain_im * d_re;
			first_s2 <= tag_s1.first;
			last_s2  <= tag_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else if (en) begin
			vld_s2 <= tag_s1.vld;
			done_q <= vld_s2 && last_s2;
		end
	end

	assign p_re = {rr_s2[PW-1], rr_s2} - {ii_s2[PW-1], ii_s2};
	assign p_im = {ri_s2[PW-1], ri_s2} + {ir_s2[PW-1], ir_s2};
	assign acc_base_re = first_s2 ? '0 : acc_re_q;
	assign acc_base_im = first_s2 ? '0 : acc_im_q;

	always_ff @(posedge clk) begin
		if (en && vld_s2) begin
			acc_re_q <= acc_base_re + AW'(p_re);
			acc_im_q <= acc_base_im + AW'(p_im);
		end
	end

	// round half up then floor by the arithmetic shift
	assign rnd_re = acc_re_q + ROUND_HALF;
	assign rnd_im = acc_im_q + ROUND_HALF;
	assign q_re = rnd_re[AW-1:15];
	assign q_im = rnd_im[AW-1:15];

	always_comb begin
		priority if (q_re > SAT_HI) sat_re = SAT_HI;
		else if (q_re < SAT_LO) sat_re = SAT_LO;
		else sat_re = q_re;
		priority if (q_im > SAT_HI) sat_im = SAT_HI;
		else if (q_im < SAT_LO) sat_im = SAT_LO;
		else sat_im = q_im;
	end

	assign res_re = sat_re[SW-1:0];
	assign res_im = sat_im[SW-1:0];
	assign done   = done_q;

endmodule

`default_nettype wire

// File: design/multipath_channel_fir_core.sv
// ----------------------------------------------------------------------------
// multipath_channel_fir_core
// Tapped delay line channel model: direct gain plus complex multipath taps
// over a 1024-entry complex delay memory.
// ----------------------------------------------------------------------------
// sample rate: a new sample is accepted only once every tap read of the last sample
//   has been issued, as the single delay memory port serves one write plus one read
//   for the direct path and one for each of 4 paths; a stalled output holds it off
// reset: control, pointer and fill count clear, registers take their reset
//   values; the delay memory is not swept, the fill count makes unwritten
//   entries read as zero, so the block is ready right after reset
`default_nettype none

module multipath_channel_fir_core (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [mcf_pkg::SAMPLE_W-1:0]    sample_re,
	input  wire logic signed [mcf_pkg::SAMPLE_W-1:0]    sample_im,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [mcf_pkg::SAMPLE_W-1:0]         out_re,
	output logic signed [mcf_pkg::SAMPLE_W-1:0]         out_im,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [mcf_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [mcf_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int AW  = mcf_pkg::ADDR_W;
	localparam int FW  = mcf_pkg::FILL_W;
	localparam int TW  = mcf_pkg::TAP_W;
	localparam int DW  = mcf_pkg::DELAY_W;
	localparam int GW  = mcf_pkg::GAIN_W;
	localparam int IW  = mcf_pkg::TAP_IDX_W;

	// configuration registers
	logic [GW-1:0]                     direct_gain_q;
	logic [mcf_pkg::CFG_DATA_W-1:0]    path_tap_q [mcf_pkg::TAP_REGS];
	logic [mcf_pkg::CFG_IDX_W-1:0]     cfg_off;

	// sequencer
	mcf_pkg::state_t state_q, state_d;
	logic [TW-1:0]   tap_q;
	logic [TW-1:0]   tap_m1;
	logic [IW-1:0]   tap_idx;
	logic            accept;
	logic            issue;
	logic            en;

	// delay line
	logic [mcf_pkg::ENTRY_W-1:0] line_mem [mcf_pkg::LINE_DEPTH];
	logic [mcf_pkg::ENTRY_W-1:0] rdata_q;
	logic [AW-1:0]               wp_q;
	logic [AW-1:0]               cur_ptr_q;
	logic [FW-1:0]               fill_q;
	logic [AW-1:0]               rd_addr;
	logic [DW-1:0]               tap_delay;
	logic [DW-1:0]               raw_delay;

	mcf_pkg::tag_t issue_tag;
	mcf_pkg::tag_t tag_s1;

	// result
	logic                               done;
	logic signed [mcf_pkg::SAMPLE_W-1:0] res_re, res_im;
	logic                               out_load;
	logic                               out_valid_q;
	logic signed [mcf_pkg::SAMPLE_W-1:0] out_re_q, out_im_q;

	// the user must see that configuration writes are only issued while idle; cfg_ready is tied high
	assign cfg_ready = 1'b1;
	assign cfg_off   = cfg_index - mcf_pkg::CFG_PATH_TAP_FIRST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direct_gain_q <= mcf_pkg::DIRECT_GAIN_RESET;
			for (int i = 0; i < mcf_pkg::TAP_REGS; i++) begin
				path_tap_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == mcf_pkg::CFG_DIRECT_GAIN) begin
				direct_gain_q <= cfg_data[GW-1:0];
			end else if (cfg_index >= mcf_pkg::CFG_PATH_TAP_FIRST &&
				cfg_index <= mcf_pkg::CFG_PATH_TAP_LAST) begin
				path_tap_q[cfg_off[IW-1:0]] <= cfg_data;
			end
		end
	end

	// whole pipeline freezes while a finished result cannot be handed over
	assign en       = !(done && out_valid_q && !out_ready);
	assign out_load = done && en;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mcf_pkg::ST_IDLE: begin
				if (accept) state_d = mcf_pkg::ST_RUN;
			end
			mcf_pkg::ST_RUN: begin
				if (en && tap_q == TW'(mcf_pkg::MAX_PATHS)) state_d = mcf_pkg::ST_IDLE;
			end
			default: state_d = mcf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			mcf_pkg::ST_IDLE: in_ready = en;
			mcf_pkg::ST_RUN:  issue    = 1'b1;
			default: begin
				in_ready = 1'b0;
				issue    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mcf_pkg::ST_IDLE;
			tap_q     <= '0;
			wp_q      <= '0;
			cur_ptr_q <= '0;
			fill_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				tap_q     <= '0;
				wp_q      <= wp_q + AW'(1);
				cur_ptr_q <= wp_q;
				if (fill_q != FW'(mcf_pkg::LINE_DEPTH)) fill_q <= fill_q + FW'(1);
			end else if (issue && en) begin
				tap_q <= tap_q + TW'(1);
			end
		end
	end

	// tap 0 is the direct path: real gain, zero delay
	assign tap_m1    = tap_q - TW'(1);
	assign tap_idx   = tap_m1[IW-1:0];
	assign raw_delay = path_tap_q[tap_idx][32 +: DW];

	always_comb begin
		issue_tag       = '0;
		tap_delay       = '0;
		issue_tag.vld   = issue;
		issue_tag.first = (tap_q == '0);
		issue_tag.last  = (tap_q == TW'(mcf_pkg::MAX_PATHS));
		if (tap_q == '0) begin
			issue_tag.gain_re = direct_gain_q;
			issue_tag.gain_im = '0;
		end else begin
			issue_tag.gain_re = path_tap_q[tap_idx][GW-1:0];
			issue_tag.gain_im = path_tap_q[tap_idx][2*GW-1:GW];
			tap_delay = (raw_delay > DW'(mcf_pkg::MAX_DELAY)) ? DW'(mcf_pkg::MAX_DELAY)
				: raw_delay;
		end
		issue_tag.live = (FW'(tap_delay) < fill_q);
	end

	assign rd_addr = cur_ptr_q - AW'(tap_delay);

	always_ff @(posedge clk) begin
		if (accept) begin
			line_mem[wp_q] <= {sample_im, sample_re};
		end else if (issue && en) begin
			rdata_q <= line_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1 <= issue_tag;
		end
	end

	mcf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_s1 (tag_s1),
		.rdata  (rdata_q),
		.done   (done),
		.res_re (res_re),
		.res_im (res_im)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_re_q <= res_re;
			out_im_q <= res_im;
		end
	end

	assign out_valid = out_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;

	ap_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before its transaction");

	ap_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(mcf_pkg::LINE_DEPTH))
		else $error("fill count beyond delay line depth");

	ap_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == mcf_pkg::ST_RUN && tap_q == '0))
		else $error("sequencer did not start on the direct tap");

	ap_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(done))
		else $error("output valid without a finished accumulation");

	ap_direct_live: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && tap_q == '0) |-> (fill_q != '0))
		else $error("direct tap read with empty delay line");

endmodule

`default_nettype wire
